>>> design/ecgpe_pkg.sv
// Shared types and constants for the ECG pulse envelope and decimator.
// No dependencies; every other design file imports this package.
`default_nettype none

package ecgpe_pkg;

  // Fixed field and state widths.
  localparam int ENV_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int DECAY_W    = 16;
  localparam int CNT_W      = 32;
  localparam int GSUM_W     = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Envelope ceiling (65535.0 in Q16.16) and group sum ceiling.
  localparam logic [ENV_W-1:0]  MIN_CEIL    = 32'hFFFF_0000;
  localparam logic [GSUM_W-1:0] SUM_MAX     = 18'h3FFFF;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 32'hFFFF_FFFF;
  localparam logic [DECAY_W-1:0] DECAY_RST  = 16'd655;

  // Transaction opcodes.
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_START  = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LED_ENABLE = 1'b0,
    CFG_DECAY      = 1'b1
  } cfg_idx_t;

  // Per-cycle step control from the pipeline to the state units.
  typedef struct packed {
    logic fire;
    logic start;
  } step_ctl_t;

endpackage

`default_nettype wire

>>> design/ecgpe_in_if.sv
// Valid/ready channel carrying one input transaction (sample or start command).
// Depends on ecgpe_pkg.
`default_nettype none

interface ecgpe_in_if
  import ecgpe_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [SAMPLE_BITS-1:0] sample_code;
  logic [CNT_W-1:0]       capture_length;

  modport source (output valid, output operation, output sample_code,
                  output capture_length, input ready);
  modport sink   (input valid, input operation, input sample_code,
                  input capture_length, output ready);
endinterface

`default_nettype wire

>>> design/ecgpe_out_if.sv
// Valid/ready channel carrying one result transaction.
// Depends on ecgpe_pkg.
`default_nettype none

interface ecgpe_out_if
  import ecgpe_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              pulse_on;
  logic              mean_valid;
  logic [GSUM_W-1:0] group_sum;
  logic              capturing;
  logic              capture_done;

  modport source (output valid, output pulse_on, output mean_valid, output group_sum,
                  output capturing, output capture_done, input ready);
  modport sink   (input valid, input pulse_on, input mean_valid, input group_sum,
                  input capturing, input capture_done, output ready);
endinterface

`default_nettype wire

>>> design/ecgpe_envelope.sv
// Min/max envelope tracker with midpoint pulse test and multiplicative decay.
// Depends on ecgpe_pkg.
`default_nettype none

module ecgpe_envelope
  import ecgpe_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire step_ctl_t              ctl,
  input  wire logic [SAMPLE_BITS-1:0] code,
  input  wire logic                   led_enable,
  input  wire logic [DECAY_W-1:0]     decay,
  output logic                        pulse
);

  localparam int VW = SAMPLE_BITS + FRAC_W;
  localparam int CW = (VW > ENV_W) ? VW : ENV_W;

  logic [ENV_W-1:0]         env_min_r, env_min_nxt;
  logic [ENV_W-1:0]         env_max_r, env_max_nxt;
  logic [VW-1:0]            v;
  logic [CW-1:0]            v_x, min_x, max_x;
  logic [ENV_W-1:0]         min_upd, max_upd;
  logic [CW:0]              mid_sum, v_dbl;
  logic [ENV_W+DECAY_W-1:0] min_prod, max_prod;
  logic [ENV_W:0]           min_grow;

  // Widen the envelope with the new code, then compare against the midpoint.
  always_comb begin
    v       = {code, {FRAC_W{1'b0}}};
    v_x     = CW'(v);
    min_x   = CW'(env_min_r);
    max_x   = CW'(env_max_r);
    min_upd = (v_x < min_x) ? v_x[ENV_W-1:0] : env_min_r;
    max_upd = (v_x > max_x) ? v_x[ENV_W-1:0] : env_max_r;
    mid_sum = {1'b0, CW'(min_upd)} + {1'b0, CW'(max_upd)};
    v_dbl   = {v_x, 1'b0};
    pulse   = led_enable && (v_dbl > mid_sum);
  end

  // Decay: min grows by (1+k) with saturation, max shrinks by (1-k).
  always_comb begin
    min_prod    = min_upd * decay;
    max_prod    = max_upd * decay;
    min_grow    = {1'b0, min_upd} + {1'b0, min_prod[ENV_W+DECAY_W-1:FRAC_W]};
    env_min_nxt = (min_grow > {1'b0, MIN_CEIL}) ? MIN_CEIL : min_grow[ENV_W-1:0];
    env_max_nxt = max_upd - max_prod[ENV_W+DECAY_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_min_r <= MIN_CEIL;
      env_max_r <= '0;
    end else if (ctl.fire && !ctl.start) begin
      env_min_r <= env_min_nxt;
      env_max_r <= env_max_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/ecgpe_capture.sv
// Block counter, capture arming and decimating group-sum accumulator.
// Depends on ecgpe_pkg.
`default_nettype none

module ecgpe_capture
  import ecgpe_pkg::*;
#(
  parameter int BLOCK_LEN   = 32,
  parameter int DECIMATION  = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire step_ctl_t              ctl,
  input  wire logic [SAMPLE_BITS-1:0] code,
  input  wire logic [CNT_W-1:0]       capture_length,
  output logic                        mean_valid,
  output logic [GSUM_W-1:0]           group_sum,
  output logic                        capturing,
  output logic                        capture_done
);

  localparam int BP_W   = $clog2(BLOCK_LEN);
  localparam int GP_W   = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int PSUM_W = SAMPLE_BITS + $clog2(DECIMATION + 1);

  logic [BP_W-1:0]   bpos_r, bpos_nxt;
  logic [GP_W-1:0]   gpos_r, gpos_nxt;
  logic [PSUM_W-1:0] psum_r, psum_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  target_r, target_nxt;
  logic              active_r, active_nxt;
  logic              pending_r, pending_nxt;

  logic              at_start, block_end, group_end, active_eff;
  logic [PSUM_W-1:0] psum_base, psum_add;
  logic [CNT_W-1:0]  count_inc, target_m1;

  // Per-transaction capture and decimation step.
  always_comb begin
    at_start   = (bpos_r == '0);
    block_end  = (bpos_r == BP_W'(BLOCK_LEN - 1));
    group_end  = (gpos_r == GP_W'(DECIMATION - 1));
    active_eff = active_r || (at_start && pending_r);
    psum_base  = at_start ? '0 : psum_r;
    psum_add   = psum_base + PSUM_W'(code);
    count_inc  = (count_r == CNT_MAX) ? count_r : count_r + CNT_W'(1);
    target_m1  = (target_r == '0) ? '0 : target_r - CNT_W'(1);

    bpos_nxt     = bpos_r;
    gpos_nxt     = gpos_r;
    psum_nxt     = psum_r;
    count_nxt    = count_r;
    target_nxt   = target_r;
    active_nxt   = active_r;
    pending_nxt  = pending_r;
    mean_valid   = 1'b0;
    group_sum    = '0;
    capture_done = 1'b0;

    if (ctl.start) begin
      // Start command: ignored while a capture is active or pending.
      if (!active_r && !pending_r) begin
        target_nxt  = capture_length;
        count_nxt   = '0;
        pending_nxt = 1'b1;
      end
    end else begin
      pending_nxt = pending_r && !at_start;
      active_nxt  = active_eff;
      psum_nxt    = psum_base;
      if (active_eff) begin
        count_nxt = count_inc;
        psum_nxt  = psum_add;
        if (group_end) begin
          mean_valid = 1'b1;
          group_sum  = (32'(psum_add) > 32'(SUM_MAX)) ? SUM_MAX : GSUM_W'(psum_add);
          psum_nxt   = '0;
        end
        if (block_end && (count_inc >= target_m1)) begin
          active_nxt   = 1'b0;
          capture_done = 1'b1;
        end
      end
      bpos_nxt = block_end ? '0 : bpos_r + BP_W'(1);
      gpos_nxt = (block_end || group_end) ? '0 : gpos_r + GP_W'(1);
    end

    capturing = active_nxt || pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpos_r    <= '0;
      gpos_r    <= '0;
      psum_r    <= '0;
      count_r   <= '0;
      target_r  <= '0;
      active_r  <= 1'b0;
      pending_r <= 1'b0;
    end else if (ctl.fire) begin
      bpos_r    <= bpos_nxt;
      gpos_r    <= gpos_nxt;
      psum_r    <= psum_nxt;
      count_r   <= count_nxt;
      target_r  <= target_nxt;
      active_r  <= active_nxt;
      pending_r <= pending_nxt;
    end
  end

  // A capture is never active and pending at the same time.
  a_no_active_and_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !(active_r && pending_r))
    else $error("capture active and pending together");

  // A finished capture leaves nothing running.
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fire && capture_done) |=> (!active_r && !pending_r))
    else $error("capture still running after done");

  // Group sums are only emitted from an active capture.
  a_sum_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fire && mean_valid) |-> active_eff)
    else $error("group sum without active capture");

endmodule

`default_nettype wire

>>> design/ecg_pulse_envelope_and_decimator.sv
// Top level: input register, envelope and capture units, result register.
// Depends on ecgpe_pkg, ecgpe_in_if, ecgpe_out_if, ecgpe_envelope, ecgpe_capture.
`default_nettype none

// The block takes one transaction per clock cycle, unless output backpressure
// stalls it, for any mix of samples and start commands. Each transaction lands
// in an input register, is processed from there by the envelope and capture
// logic, and its result is held in an output register; the longest path is
// the 32x16 decay multiply and its add. Input ready stays high while the
// output register is empty or being drained, so backpressure stalls the block
// only when both registers hold data. Configuration (led_enable, decay_q16) is
// written through the cfg port while no transaction is in flight and takes
// effect on the next one.

module ecg_pulse_envelope_and_decimator
  import ecgpe_pkg::*;
#(
  parameter int BLOCK_LEN   = 32,
  parameter int DECIMATION  = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ecgpe_in_if.sink                   in_if,
  ecgpe_out_if.source                out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic                   led_enable_r;
  logic [DECAY_W-1:0]     decay_r;

  logic                   in_valid_r;
  logic                   op_r;
  logic [SAMPLE_BITS-1:0] code_r;
  logic [CNT_W-1:0]       len_r;

  logic                   out_valid_r;
  logic                   pulse_r, mean_valid_r, capturing_r, done_r;
  logic [GSUM_W-1:0]      gsum_r;

  logic                   adv, fire, in_take;
  step_ctl_t              ctl;
  logic [SAMPLE_BITS-1:0] code_conv;
  logic                   pulse_c, mean_valid_c, capturing_c, done_c;
  logic [GSUM_W-1:0]      gsum_c;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_enable_r <= 1'b0;
      decay_r      <= DECAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LED_ENABLE: led_enable_r <= cfg_data[0];
        CFG_DECAY:      decay_r      <= cfg_data[DECAY_W-1:0];
      endcase
    end
  end

  // Pipeline handshake: the stage advances when the result slot is free or being drained.
  always_comb begin
    adv         = !out_valid_r || out_if.ready;
    fire        = in_valid_r && adv;
    in_if.ready = !in_valid_r || adv;
    in_take     = in_if.valid && in_if.ready;
    ctl.fire    = fire;
    ctl.start   = (op_t'(op_r) == OP_START);
    // Offset binary to unsigned: flip the sign bit.
    code_conv   = code_r ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_if.operation;
      code_r <= in_if.sample_code;
      len_r  <= in_if.capture_length;
    end
  end

  ecgpe_envelope #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_envelope (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .code       (code_conv),
    .led_enable (led_enable_r),
    .decay      (decay_r),
    .pulse      (pulse_c)
  );

  ecgpe_capture #(
    .BLOCK_LEN   (BLOCK_LEN),
    .DECIMATION  (DECIMATION),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_capture (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .code           (code_conv),
    .capture_length (len_r),
    .mean_valid     (mean_valid_c),
    .group_sum      (gsum_c),
    .capturing      (capturing_c),
    .capture_done   (done_c)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pulse_r      <= pulse_c && !ctl.start;
      mean_valid_r <= mean_valid_c;
      gsum_r       <= gsum_c;
      capturing_r  <= capturing_c;
      done_r       <= done_c;
    end
  end

  always_comb begin
    out_if.valid        = out_valid_r;
    out_if.pulse_on     = pulse_r;
    out_if.mean_valid   = mean_valid_r;
    out_if.group_sum    = gsum_r;
    out_if.capturing    = capturing_r;
    out_if.capture_done = done_r;
  end

  // Every processed transaction produces a result in the next cycle.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed transaction produced no result");

  // A stalled input transaction is kept until processed.
  a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> in_valid_r)
    else $error("stalled transaction dropped");

  // A group sum only comes from a running capture or the one that just ended.
  a_sum_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && mean_valid_r) |-> (capturing_r || done_r))
    else $error("group sum outside a capture");

endmodule

`default_nettype wire
